// ----- rtl/core/qkde_pkg.sv -----
package qkde_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int PADDR_W   = 2 * IDX_W;
  localparam int KEY_W     = 47;
  localparam int SUM_W     = 53;
  localparam int CAP_W     = 22;
  localparam int WS_W      = 23;
  localparam int ACC_W     = 22;

  localparam logic [2:0] OP_LOAD_ITEM = 3'd0;
  localparam logic [2:0] OP_LOAD_PEN  = 3'd1;
  localparam logic [2:0] OP_ADD       = 3'd2;
  localparam logic [2:0] OP_REMOVE    = 3'd3;
  localparam logic [2:0] OP_QUERY     = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_OVER     = 2'd2;
  localparam logic [1:0] ST_INDEX    = 2'd3;

  localparam logic [1:0] CFG_BUDGET = 2'd0;
  localparam logic [1:0] CFG_ACTIVE = 2'd1;

  typedef struct packed {
    logic capture;
    logic rd_item;
    logic check;
    logic load_item;
    logic pen_wr0;
    logic pen_wr1;
    logic walk_clr;
    logic walk_step;
    logic commit_add;
    logic commit_rem;
    logic clear;
    logic finish;
  } qkde_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] code;
    logic       walk_done;
    logic       out_busy;
  } qkde_stat_t;

endpackage

// ----- rtl/core/quadratic_knapsack_delta_eval.sv -----
// Flow: capture, item read and check; then an accepted load item writes the item
// tables, an accepted load penalty writes both matrix halves, an accepted add or
// remove walks the 64-entry penalty row (one read per cycle) before its commit.
// Throughput: one request at a time; next request accepted the cycle after
// the result is registered, while that result still waits.
// Reset (rst, synchronous): sack empty, sums zero, budget 0, active_items 64;
// item tables and penalty matrix hold no defined value until written.
module quadratic_knapsack_delta_eval (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [qkde_pkg::CAP_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 opcode,
  input  logic [qkde_pkg::IDX_W-1:0] item_index,
  input  logic [qkde_pkg::IDX_W-1:0] other_index,
  input  logic [15:0]                profit,
  input  logic [15:0]                weight,
  input  logic [15:0]                penalty,
  input  logic [qkde_pkg::KEY_W-1:0] item_key,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         total_cost,
  output logic [qkde_pkg::CAP_W-1:0] sack_weight,
  output logic [qkde_pkg::CNT_W-1:0] items_in_sack,
  output logic [qkde_pkg::SUM_W-1:0] solution_key,
  output logic                       is_member,
  output logic                       fits,
  output logic [1:0]                 status
);

  qkde_pkg::qkde_cmd_t  cmd;
  qkde_pkg::qkde_stat_t st;

  assign cfg_ready = 1'b1;

  qkde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  qkde_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .item_index    (item_index),
    .other_index   (other_index),
    .profit        (profit),
    .weight        (weight),
    .penalty       (penalty),
    .item_key      (item_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .total_cost    (total_cost),
    .sack_weight   (sack_weight),
    .items_in_sack (items_in_sack),
    .solution_key  (solution_key),
    .is_member     (is_member),
    .fits          (fits),
    .status        (status)
  );

endmodule

// ----- rtl/core/qkde_ctrl.sv -----
module qkde_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  qkde_pkg::qkde_stat_t st,
  output qkde_pkg::qkde_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CHECK, S_BRANCH, S_PEN2, S_WALK, S_DRAIN, S_COMMIT, S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_item = 1'b1;
        state_next  = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_BRANCH;
      end
      S_BRANCH: begin
        state_next = S_DONE;
        if (st.code == qkde_pkg::ST_OK) begin
          case (st.op) inside
            qkde_pkg::OP_LOAD_ITEM: cmd.load_item = 1'b1;
            qkde_pkg::OP_LOAD_PEN: begin
              cmd.pen_wr0 = 1'b1;
              state_next  = S_PEN2;
            end
            qkde_pkg::OP_ADD, qkde_pkg::OP_REMOVE: begin
              cmd.walk_clr = 1'b1;
              state_next   = S_WALK;
            end
            qkde_pkg::OP_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_PEN2: begin
        cmd.pen_wr1 = 1'b1;
        state_next  = S_DONE;
      end
      S_WALK: begin
        if (st.walk_done) state_next = S_DRAIN;
        else cmd.walk_step = 1'b1;
      end
      S_DRAIN: state_next = S_COMMIT;
      S_COMMIT: begin
        if (st.op == qkde_pkg::OP_ADD) cmd.commit_add = 1'b1;
        else cmd.commit_rem = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ----- rtl/core/qkde_dp.sv -----
module qkde_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  qkde_pkg::qkde_cmd_t                  cmd,
  output qkde_pkg::qkde_stat_t                 st,
  input  logic                                cfg_valid,
  input  logic [1:0]                          cfg_index,
  input  logic [qkde_pkg::CAP_W-1:0]          cfg_data,
  input  logic [2:0]                          opcode,
  input  logic [qkde_pkg::IDX_W-1:0]          item_index,
  input  logic [qkde_pkg::IDX_W-1:0]          other_index,
  input  logic [15:0]                         profit,
  input  logic [15:0]                         weight,
  input  logic [15:0]                         penalty,
  input  logic [qkde_pkg::KEY_W-1:0]          item_key,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  total_cost,
  output logic [qkde_pkg::CAP_W-1:0]          sack_weight,
  output logic [qkde_pkg::CNT_W-1:0]          items_in_sack,
  output logic [qkde_pkg::SUM_W-1:0]          solution_key,
  output logic                                is_member,
  output logic                                fits,
  output logic [1:0]                          status
);

  logic [qkde_pkg::CAP_W-1:0] budget;
  logic [qkde_pkg::CNT_W-1:0] active_items;

  logic [2:0]                 op_r;
  logic [qkde_pkg::IDX_W-1:0] a_r, b_r;
  logic [15:0]                profit_r, weight_r, pen_r;
  logic [qkde_pkg::KEY_W-1:0] key_r;

  logic [15:0]                prof_mem [qkde_pkg::MAX_ITEMS];
  logic [15:0]                wt_mem   [qkde_pkg::MAX_ITEMS];
  logic [qkde_pkg::KEY_W-1:0] key_mem  [qkde_pkg::MAX_ITEMS];
  logic [15:0]                pen_mem  [qkde_pkg::MAX_ITEMS * qkde_pkg::MAX_ITEMS];
  logic [15:0]                prof_q, wt_q, pen_q;
  logic [qkde_pkg::KEY_W-1:0] key_q;

  logic [qkde_pkg::MAX_ITEMS-1:0] member;
  logic [31:0]                    cost;
  logic [qkde_pkg::WS_W-1:0]      ws;
  logic [qkde_pkg::CNT_W-1:0]     cnt;
  logic [qkde_pkg::SUM_W-1:0]     ks;

  logic [qkde_pkg::CNT_W-1:0] j;
  logic [qkde_pkg::IDX_W-1:0] rj;
  logic                       rvld;
  logic [qkde_pkg::ACC_W-1:0] acc;
  logic [1:0]                 code_r;

  logic [qkde_pkg::CNT_W-1:0] lim;
  logic                       bad_idx, fit_now, fit_out;
  logic [1:0]                 code;
  logic [15:0]                wsel;
  logic                       pen_we;
  logic [qkde_pkg::PADDR_W-1:0] pen_waddr;

  assign lim = (active_items > qkde_pkg::CNT_W'(qkde_pkg::MAX_ITEMS)) ?
               qkde_pkg::CNT_W'(qkde_pkg::MAX_ITEMS) : active_items;
  assign bad_idx = ({1'b0, a_r} >= lim) ||
                   (op_r == qkde_pkg::OP_LOAD_PEN && {1'b0, b_r} >= lim);
  assign fit_now = ({8'd0, wt_q} + {1'b0, ws}) <= {2'b00, budget};

  always_comb begin
    code = qkde_pkg::ST_OK;
    if (op_r <= qkde_pkg::OP_QUERY && bad_idx) code = qkde_pkg::ST_INDEX;
    else begin
      case (op_r) inside
        qkde_pkg::OP_LOAD_ITEM: if (member[a_r]) code = qkde_pkg::ST_CONFLICT;
        qkde_pkg::OP_LOAD_PEN:
          if (member[a_r] && member[b_r]) code = qkde_pkg::ST_CONFLICT;
        qkde_pkg::OP_ADD, qkde_pkg::OP_QUERY: begin
          if (member[a_r]) code = qkde_pkg::ST_CONFLICT;
          else if (!fit_now) code = qkde_pkg::ST_OVER;
        end
        qkde_pkg::OP_REMOVE: if (!member[a_r]) code = qkde_pkg::ST_CONFLICT;
        default: ;
      endcase
    end
  end

  assign wsel    = (op_r == qkde_pkg::OP_LOAD_ITEM) ? weight_r : wt_q;
  assign fit_out = ({8'd0, wsel} + {1'b0, ws}) <= {2'b00, budget};

  assign st.op        = op_r;
  assign st.code      = code_r;
  assign st.walk_done = (j == qkde_pkg::CNT_W'(qkde_pkg::MAX_ITEMS));
  assign st.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget       <= '0;
      active_items <= qkde_pkg::CNT_W'(qkde_pkg::MAX_ITEMS);
    end else if (cfg_valid) begin
      if (cfg_index == qkde_pkg::CFG_BUDGET) budget <= cfg_data;
      else if (cfg_index == qkde_pkg::CFG_ACTIVE) active_items <= cfg_data[qkde_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= opcode;
      a_r      <= item_index;
      b_r      <= other_index;
      profit_r <= profit;
      weight_r <= weight;
      pen_r    <= penalty;
      key_r    <= item_key;
    end
    if (cmd.check) code_r <= code;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      prof_mem[a_r] <= profit_r;
      wt_mem[a_r]   <= weight_r;
      key_mem[a_r]  <= key_r;
    end
    if (cmd.rd_item) begin
      prof_q <= prof_mem[a_r];
      wt_q   <= wt_mem[a_r];
      key_q  <= key_mem[a_r];
    end
  end

  assign pen_we    = cmd.pen_wr0 || cmd.pen_wr1;
  assign pen_waddr = cmd.pen_wr0 ? {a_r, b_r} : {b_r, a_r};

  always_ff @(posedge clk) begin
    if (pen_we) pen_mem[pen_waddr] <= pen_r;
    pen_q <= pen_mem[{a_r, j[qkde_pkg::IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvld <= 1'b0;
    end else begin
      rvld <= cmd.walk_step;
    end
    if (cmd.walk_clr) begin
      j   <= '0;
      acc <= '0;
    end else begin
      if (cmd.walk_step) begin
        j  <= j + qkde_pkg::CNT_W'(1);
        rj <= j[qkde_pkg::IDX_W-1:0];
      end
      if (rvld && rj != a_r && member[rj]) acc <= acc + {6'd0, pen_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      member <= '0;
      cost   <= '0;
      ws     <= '0;
      cnt    <= '0;
      ks     <= '0;
    end else if (cmd.commit_add) begin
      member[a_r] <= 1'b1;
      cost <= cost + {16'd0, prof_q} - {10'd0, acc};
      ws   <= ws + {7'd0, wt_q};
      cnt  <= cnt + qkde_pkg::CNT_W'(1);
      ks   <= ks + {6'd0, key_q};
    end else if (cmd.commit_rem) begin
      member[a_r] <= 1'b0;
      cost <= cost + {10'd0, acc} - {16'd0, prof_q};
      ws   <= ws - {7'd0, wt_q};
      cnt  <= cnt - qkde_pkg::CNT_W'(1);
      ks   <= ks - {6'd0, key_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.finish) begin
      total_cost    <= cost;
      sack_weight   <= ws[qkde_pkg::CAP_W-1:0];
      items_in_sack <= cnt;
      solution_key  <= ks;
      status        <= code_r;
      if (op_r <= qkde_pkg::OP_QUERY && code_r != qkde_pkg::ST_INDEX) begin
        is_member <= member[a_r];
        fits      <= !member[a_r] && fit_out;
      end else begin
        is_member <= 1'b0;
        fits      <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/qkde_checker.sv -----
module qkde_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [qkde_pkg::CNT_W-1:0] items_in_sack,
  input logic                       is_member,
  input logic                       fits,
  input logic [1:0]                 status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> items_in_sack <= qkde_pkg::CNT_W'(qkde_pkg::MAX_ITEMS))
    else $error("count out of range");

  a_idx_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == qkde_pkg::ST_INDEX |-> !is_member && !fits)
    else $error("flags on bad index");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_member && fits)) else $error("member and fits");

endmodule

bind quadratic_knapsack_delta_eval qkde_checker u_qkde_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .items_in_sack (items_in_sack),
  .is_member     (is_member),
  .fits          (fits),
  .status        (status)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import qkde_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [2:0]       op;
    logic [5:0]       a;
    logic [5:0]       b;
    logic [15:0]      prof;
    logic [15:0]      wt;
    logic [15:0]      pen;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct {
    logic [31:0]      cost;
    logic [CAP_W-1:0] cap;
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] ksum;
    logic             mem;
    logic             fit;
    logic [1:0]       st;
  } sack_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] opcode = '0;
  logic [IDX_W-1:0] item_index = '0;
  logic [IDX_W-1:0] other_index = '0;
  logic [15:0] profit = '0;
  logic [15:0] weight = '0;
  logic [15:0] penalty = '0;
  logic [KEY_W-1:0] item_key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] total_cost;
  logic [CAP_W-1:0] sack_weight;
  logic [CNT_W-1:0] items_in_sack;
  logic [SUM_W-1:0] solution_key;
  logic is_member;
  logic fits;
  logic [1:0] status;

  quadratic_knapsack_delta_eval u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow state of the sack
  bit [15:0] prof_tab [MAX_ITEMS];
  bit [15:0] wt_tab [MAX_ITEMS];
  bit [KEY_W-1:0] key_tab [MAX_ITEMS];
  bit [15:0] pen_mat [MAX_ITEMS][MAX_ITEMS];
  bit item_ok [MAX_ITEMS];
  bit pen_ok [MAX_ITEMS][MAX_ITEMS];
  bit in_sack [MAX_ITEMS];
  bit [31:0] cost_acc;
  bit [WS_W-1:0] wsum;
  bit [CNT_W-1:0] nmem;
  bit [SUM_W-1:0] ksum_acc;
  bit [CAP_W-1:0] cap_limit;
  bit [6:0] act_cfg = 7'd64;

  sack_res_t sack_q [$];
  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int idle_cyc = 0;

  function automatic int act_lim();
    return (act_cfg > 7'(MAX_ITEMS)) ? MAX_ITEMS : int'(act_cfg);
  endfunction

  function automatic bit [31:0] row_sum(int a);
    bit [31:0] s = 0;
    for (int j = 0; j < MAX_ITEMS; j++)
      if (j != a && in_sack[j]) s += {16'd0, pen_mat[a][j]};
    return s;
  endfunction

  function automatic bit fits_chk(int a);
    return ({8'd0, wt_tab[a]} + {1'b0, wsum}) <= {2'd0, cap_limit};
  endfunction

  function automatic sack_res_t sack_predict(req_t r);
    sack_res_t x;
    int a = r.a;
    int b = r.b;
    bit addr = 0;
    x.st = ST_OK;
    if (r.op <= OP_QUERY) begin
      if (a >= act_lim() || (r.op == OP_LOAD_PEN && b >= act_lim())) begin
        x.st = ST_INDEX;
      end else begin
        addr = 1;
        case (r.op)
          OP_LOAD_ITEM: begin
            if (in_sack[a]) x.st = ST_CONFLICT;
            else begin
              prof_tab[a] = r.prof;
              wt_tab[a] = r.wt;
              key_tab[a] = r.key;
              item_ok[a] = 1;
            end
          end
          OP_LOAD_PEN: begin
            if (in_sack[a] && in_sack[b]) x.st = ST_CONFLICT;
            else begin
              pen_mat[a][b] = r.pen;
              pen_mat[b][a] = r.pen;
              pen_ok[a][b] = 1;
              pen_ok[b][a] = 1;
            end
          end
          OP_ADD: begin
            if (in_sack[a]) x.st = ST_CONFLICT;
            else if (!fits_chk(a)) x.st = ST_OVER;
            else begin
              cost_acc += {16'd0, prof_tab[a]} - row_sum(a);
              in_sack[a] = 1;
              wsum += {7'd0, wt_tab[a]};
              nmem += 7'd1;
              ksum_acc += {6'd0, key_tab[a]};
            end
          end
          OP_REMOVE: begin
            if (!in_sack[a]) x.st = ST_CONFLICT;
            else begin
              in_sack[a] = 0;
              cost_acc += row_sum(a) - {16'd0, prof_tab[a]};
              wsum -= {7'd0, wt_tab[a]};
              nmem -= 7'd1;
              ksum_acc -= {6'd0, key_tab[a]};
            end
          end
          default: begin
            if (in_sack[a]) x.st = ST_CONFLICT;
            else if (!fits_chk(a)) x.st = ST_OVER;
          end
        endcase
      end
    end else if (r.op == OP_CLEAR) begin
      foreach (in_sack[i]) in_sack[i] = 0;
      cost_acc = 0;
      wsum = 0;
      nmem = 0;
      ksum_acc = 0;
    end
    x.cost = cost_acc;
    x.cap = wsum[CAP_W-1:0];
    x.cnt = nmem;
    x.ksum = ksum_acc;
    x.mem = addr && in_sack[a];
    x.fit = addr && !in_sack[a] && fits_chk(a);
    return x;
  endfunction

  task automatic send_req(req_t r);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= r.op;
    item_index <= r.a;
    other_index <= r.b;
    profit <= r.prof;
    weight <= r.wt;
    penalty <= r.pen;
    item_key <= r.key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sack_q.insert(sack_q.size(), sack_predict(r));
    n_req++;
  endtask

  task automatic send_op(logic [2:0] op, int a, int b = 0, int pv = 0, int wv = 0,
                         int pen = 0, logic [KEY_W-1:0] key = '0);
    req_t r;
    r.op = op;
    r.a = 6'(a);
    r.b = 6'(b);
    r.prof = 16'(pv);
    r.wt = 16'(wv);
    r.pen = 16'(pen);
    r.key = key;
    send_req(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sack_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [CAP_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_BUDGET) cap_limit = val;
    else if (idx == CFG_ACTIVE) act_cfg = val[6:0];
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return KEY_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic req_t gen_req();
    req_t r;
    int x = $urandom_range(99);
    int lim = act_lim();
    int a;
    int miss;
    int mlist [$];
    if (x < 10) r.op = OP_LOAD_ITEM;
    else if (x < 25) r.op = OP_LOAD_PEN;
    else if (x < 55) r.op = OP_ADD;
    else if (x < 75) r.op = OP_REMOVE;
    else if (x < 87) r.op = OP_QUERY;
    else if (x < 90) r.op = OP_CLEAR;
    else if (x < 92) r.op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
    else r.op = OP_ADD;
    if (lim > 0 && $urandom_range(9) != 0) begin
      r.a = 6'($urandom_range(lim - 1));
      r.b = 6'($urandom_range(lim - 1));
    end else begin
      r.a = 6'($urandom_range(63));
      r.b = 6'($urandom_range(63));
    end
    foreach (in_sack[i]) if (in_sack[i]) mlist.insert(mlist.size(), i);
    if (r.op == OP_REMOVE && mlist.size() != 0 && $urandom_range(9) < 7)
      r.a = 6'(mlist[$urandom_range(mlist.size() - 1)]);
    r.prof = 16'($urandom);
    r.wt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
    r.pen = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(300));
    r.key = rand_key();
    a = r.a;
    // keep every table read on written entries
    if (r.op >= OP_LOAD_PEN && r.op <= OP_QUERY && a < lim && !in_sack[a]
        && !(r.op == OP_LOAD_PEN && r.b >= lim)) begin
      miss = -1;
      if (r.op == OP_ADD)
        foreach (in_sack[j]) if (j != a && in_sack[j] && !pen_ok[a][j]) miss = j;
      if (!item_ok[a]) r.op = OP_LOAD_ITEM;
      else if (miss >= 0) begin
        if (miss < lim) begin
          r.op = OP_LOAD_PEN;
          r.b = 6'(miss);
        end else r.op = OP_CLEAR;
      end
    end
    return r;
  endfunction

  function automatic void chk(string n, logic [63:0] e, logic [63:0] v);
    if (e !== v) begin
      errors++;
      $display("%0t mismatch %s expected %0h actual %0h", $time, n, e, v);
    end
  endfunction

  always @(posedge clk) begin
    sack_res_t e;
    if (!rst && out_valid && out_ready) begin
      n_res++;
      if (sack_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual cost %0h", $time, total_cost);
      end else begin
        e = sack_q[0];
        sack_q.delete(0);
        chk("total_cost", {32'd0, e.cost}, {32'd0, total_cost});
        chk("sack_weight", {42'd0, e.cap}, {42'd0, sack_weight});
        chk("items_in_sack", {57'd0, e.cnt}, {57'd0, items_in_sack});
        chk("solution_key", {11'd0, e.ksum}, {11'd0, solution_key});
        chk("is_member", {63'd0, e.mem}, {63'd0, is_member});
        chk("fits", {63'd0, e.fit}, {63'd0, fits});
        chk("status", {62'd0, e.st}, {62'd0, status});
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    cfg_write(CFG_BUDGET, '1);
    cfg_write(CFG_ACTIVE, 22'd64);
    send_op(OP_LOAD_ITEM, 0, 0, 0, 0, 0, '0);
    send_op(OP_LOAD_ITEM, 1, 0, 16'hffff, 16'hffff, 0, '1);
    send_op(OP_LOAD_ITEM, 63, 0, 1234, 77, 0, 47'd100000000000000);
    send_op(OP_LOAD_PEN, 0, 1, 0, 0, 16'hffff);
    send_op(OP_LOAD_PEN, 0, 63, 0, 0, 55);
    send_op(OP_LOAD_PEN, 1, 63, 0, 0, 0);
    send_op(OP_LOAD_PEN, 63, 63, 0, 0, 999);
    send_op(OP_ADD, 0);
    send_op(OP_ADD, 0);
    send_op(OP_ADD, 1);
    send_op(OP_QUERY, 1);
    send_op(OP_QUERY, 63);
    send_op(OP_ADD, 63);
    send_op(OP_LOAD_ITEM, 1, 0, 5, 5, 0, '0);
    send_op(OP_LOAD_PEN, 0, 1, 0, 0, 3);
    send_op(OP_REMOVE, 1);
    send_op(OP_REMOVE, 1);
    send_op(OP_SPARE6, 5);
    send_op(OP_SPARE7, 63);
    send_op(OP_CLEAR, 0);
    send_op(OP_ADD, 1);
    cfg_write(CFG_BUDGET, '0);
    send_op(OP_ADD, 0);
    send_op(OP_QUERY, 63);
    send_op(OP_ADD, 63);
    cfg_write(CFG_ACTIVE, 22'd2);
    send_op(OP_ADD, 63);
    send_op(OP_LOAD_PEN, 0, 63, 0, 0, 1);
    send_op(OP_REMOVE, 1);
    cfg_write(CFG_ACTIVE, 22'd0);
    send_op(OP_QUERY, 0);
    cfg_write(CFG_ACTIVE, 22'd127);
    send_op(OP_QUERY, 63);
    send_op(OP_CLEAR, 0);
  endtask

  task automatic test_random(int n, int s_idle, int r_idle);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    cfg_write(CFG_BUDGET, ($urandom_range(4) == 0) ? 22'h3fffff :
              CAP_W'($urandom_range(20000, 300000)));
    cfg_write(CFG_ACTIVE, ($urandom_range(3) == 0) ? 22'd64 : CAP_W'($urandom_range(1, 64)));
    for (int i = 0; i < n; i++) send_req(gen_req());
  endtask

  task automatic test_backpressure();
    snd_idle = 0;
    rcv_idle = 0;
    cfg_write(CFG_ACTIVE, 22'd8);
    hold_seq++;
    for (int i = 0; i < 40; i++) send_req(gen_req());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(430, 10, 47);
    test_random(430, 47, 10);
    test_backpressure();
    test_random(400, 0, 0);
    wait_drained();
    $display("Covered %0d requests and %0d results over all opcodes, budget and", n_req, n_res);
    $display("active-count extremes, random idling and a long output stall.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/qkde_pkg.sv
rtl/core/qkde_ctrl.sv
rtl/core/qkde_dp.sv
rtl/core/quadratic_knapsack_delta_eval.sv
rtl/core/qkde_checker.sv
tb/sv/tb.sv
